[rtl/bpfa_pkg.sv]
// Package for the bitmap page-frame allocator: sizes, codes and beat types.
// Depends on nothing; the top level takes it by wildcard import.
package bpfa_pkg;

  localparam int FRAMES     = 262144;
  localparam int PAGE_BITS  = 12;
  localparam int MAP_WORDS  = (FRAMES + 63) / 64;
  localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FRAME_W    = $clog2(FRAMES) + 1;
  localparam int CNT_W      = 19;
  localparam int PADDR_W    = 30;
  localparam logic [63:0] ADDR_LIMIT  = 64'(FRAMES) << PAGE_BITS;
  localparam logic [63:0] OFFSET_MASK = (64'h1 << PAGE_BITS) - 64'h1;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_RESERVE = 3'd1,
    OP_SEAL    = 3'd2,
    OP_ALLOC   = 3'd3,
    OP_FREE    = 3'd4,
    OP_QUERY   = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NOT_SEALED = 4'd1,
    ST_SEALED     = 4'd2,
    ST_EXHAUSTED  = 4'd3,
    ST_BAD_ADDR   = 4'd4,
    ST_UNMANAGED  = 4'd5,
    ST_DUP_FREE   = 4'd6,
    ST_RESERVED   = 4'd7,
    ST_NONE_FREE  = 4'd8
  } status_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] address;
    logic [63:0] extent;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [PADDR_W-1:0] page_address;
    logic               is_managed;
    logic               is_allocated;
    logic [CNT_W-1:0]   managed_count;
    logic [CNT_W-1:0]   free_count;
    logic [CNT_W-1:0]   allocated_count;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] owned;
    logic [63:0] taken;
    logic [63:0] managed;
  } map_word_t;

endpackage

[rtl/bitmap_page_frame_allocator.sv]
// Bitmap page-frame allocator top level: sequencer, bitmap memory, counters.
// Depends on bpfa_pkg for sizes, operation and status codes and beat types.
//
// Items refused up front, and seal, go straight to the result; free and query
// read and check one bitmap word; range items read, modify and count each word
// touched; allocate reads and checks words from the first until one has a free
// frame, so the worst case scans all MAP_WORDS words. One item at a time; the
// single bitmap memory port and its registered read set the per-word cost.
// Reset: synchronous, active low. A clearing pass then writes every bitmap word
// (MAP_WORDS of them, 4096); no beat is taken until it finishes.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_PREP0, S_PREP1, S_RW_RD, S_RW_MOD, S_RW_CNT,
    S_SC_RD, S_SC_CHK, S_PT_RD, S_PT_CHK, S_FIN
  } state_t;

  // the three maps share one word address, so they live side by side
  map_word_t mem [MAP_WORDS];
  map_word_t rd_q;

  state_t             state_r;
  logic [WORD_AW-1:0] word_r;
  logic [2:0]         op_r;
  logic [63:0]        a_r, e_r;
  logic               skip_r;
  logic [FRAME_W-1:0] first_r, last_r;
  logic [5:0]         bit_r;
  logic [63:0]        chg_r;
  logic [CNT_W-1:0]   man_r, free_r, alloc_r;
  logic               sealed_r;
  logic [3:0]         status_r;
  logic [PADDR_W-1:0] paddr_r;
  logic               qm_r, qa_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  logic               rd_en, wr_en;
  logic [WORD_AW-1:0] wr_addr;
  map_word_t          wr_data;

  function automatic logic [6:0] popcount(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) n = n + 7'(v[i]);
    return n;
  endfunction

  function automatic logic [5:0] lowest(input logic [63:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 63; i >= 0; i--) if (v[i]) n = 6'(i);
    return n;
  endfunction

  // range bounds, word window and per-word mask
  logic [64:0] sum_add;
  logic [63:0] base_up, base_dn, end_up, end_clip;
  logic [FRAME_W-1:0] fr_first, fr_last;
  logic [FRAME_W-1:0] last_m1;
  logic [WORD_AW-1:0] w_last;
  logic [63:0] mask, mask_lo, mask_hi, avail, rw_chg;
  map_word_t   rw_word, sc_word, fr_word;
  logic [FRAME_W-1:0] frame_in;
  logic [63:0] f_addr;

  assign sum_add  = {1'b0, in_data.address} + {1'b0, in_data.extent};
  assign base_up  = (in_data.address + OFFSET_MASK) & ~OFFSET_MASK;
  assign base_dn  = in_data.address & ~OFFSET_MASK;
  assign end_up   = (in_data.extent + OFFSET_MASK) & ~OFFSET_MASK;
  assign end_clip = (op_r == OP_ADD) ? (e_r & ~OFFSET_MASK)
                  : ((e_r > ADDR_LIMIT || e_r < a_r) ? ADDR_LIMIT : e_r);
  assign fr_first = a_r[PAGE_BITS +: FRAME_W];
  assign fr_last  = end_clip[PAGE_BITS +: FRAME_W];
  assign last_m1  = last_r - FRAME_W'(1);
  assign w_last   = last_m1[6 +: WORD_AW];
  assign mask_lo  = (word_r == first_r[6 +: WORD_AW]) ? (~64'h0 << first_r[5:0]) : ~64'h0;
  assign mask_hi  = (word_r == last_r[6 +: WORD_AW] && last_r[5:0] != 6'd0)
                  ? ((64'h1 << last_r[5:0]) - 64'h1) : ~64'h0;
  assign mask     = mask_lo & mask_hi;
  assign avail    = rd_q.managed & ~rd_q.taken;
  assign frame_in = in_data.address[PAGE_BITS +: FRAME_W];
  assign f_addr   = {{(64-WORD_AW-6){1'b0}}, word_r, lowest(avail)} << PAGE_BITS;

  always_comb begin
    rw_word = rd_q;
    if (op_r == OP_ADD) begin
      rw_chg          = mask & ~rd_q.managed;
      rw_word.managed = rd_q.managed | rw_chg;
      rw_word.taken   = rd_q.taken & ~rw_chg;
    end else begin
      rw_chg        = mask & rd_q.managed & ~rd_q.taken;
      rw_word.taken = rd_q.taken | rw_chg;
    end
    sc_word = rd_q;
    sc_word.taken[lowest(avail)] = 1'b1;
    sc_word.owned[lowest(avail)] = 1'b1;
    fr_word = rd_q;
    fr_word.taken[bit_r] = 1'b0;
    fr_word.owned[bit_r] = 1'b0;
  end

  // memory port control
  always_comb begin
    rd_en   = (state_r == S_RW_RD) || (state_r == S_SC_RD) || (state_r == S_PT_RD);
    wr_en   = 1'b0;
    wr_addr = word_r;
    wr_data = rd_q;
    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_data = '{owned: 64'h0, taken: ~64'h0, managed: 64'h0};
      end
      S_RW_MOD: begin
        wr_en   = 1'b1;
        wr_data = rw_word;
      end
      S_SC_CHK: begin
        wr_en   = (avail != 64'h0);
        wr_data = sc_word;
      end
      S_PT_CHK: begin
        wr_en   = (op_r == OP_FREE) && rd_q.managed[bit_r] && rd_q.owned[bit_r]
                  && rd_q.taken[bit_r];
        wr_data = fr_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[word_r];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      word_r      <= '0;
      sealed_r    <= 1'b0;
      man_r       <= '0;
      free_r      <= '0;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a fresh result, or drop the old one once the far side takes it
      if (state_r == S_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          // sweep every word to its reset pattern
          if (word_r == WORD_AW'(MAP_WORDS - 1)) begin
            word_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            word_r <= word_r + WORD_AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.operation;
            paddr_r  <= '0;
            qm_r     <= 1'b0;
            qa_r     <= 1'b0;
            bit_r    <= frame_in[5:0];
            priority case (in_data.operation)
              OP_ADD, OP_RESERVE: begin
                if (sealed_r) begin
                  status_r <= ST_SEALED;
                  state_r  <= S_FIN;
                end else if (in_data.operation == OP_ADD) begin
                  status_r <= ST_OK;
                  a_r     <= base_up;
                  e_r     <= (sum_add[64] || sum_add[63:0] > ADDR_LIMIT)
                             ? ADDR_LIMIT : sum_add[63:0];
                  skip_r  <= (in_data.extent == 64'h0) || (in_data.address >= ADDR_LIMIT);
                  state_r <= S_PREP0;
                end else begin
                  status_r <= ST_OK;
                  a_r     <= base_dn;
                  e_r     <= end_up;
                  skip_r  <= (base_dn >= ADDR_LIMIT);
                  state_r <= S_PREP0;
                end
              end
              OP_SEAL: begin
                if (sealed_r) begin
                  status_r <= ST_SEALED;
                end else if (free_r == '0) begin
                  status_r <= ST_NONE_FREE;
                end else begin
                  status_r <= ST_OK;
                  alloc_r  <= man_r - free_r;
                  sealed_r <= 1'b1;
                end
                state_r <= S_FIN;
              end
              OP_ALLOC: begin
                word_r <= '0;
                if (!sealed_r) begin
                  status_r <= ST_NOT_SEALED;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_SC_RD;
                end
              end
              OP_FREE, OP_QUERY: begin
                word_r <= frame_in[6 +: WORD_AW];
                if (in_data.operation == OP_FREE && !sealed_r) begin
                  status_r <= ST_NOT_SEALED;
                  state_r  <= S_FIN;
                end else if ((in_data.address & OFFSET_MASK) != 64'h0
                             || in_data.address >= ADDR_LIMIT) begin
                  status_r <= (in_data.operation == OP_FREE) ? ST_BAD_ADDR : ST_OK;
                  state_r  <= S_FIN;
                end else begin
                  status_r <= ST_OK;
                  state_r  <= S_PT_RD;
                end
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_FIN;
              end
            endcase
          end
        end
        S_PREP0: begin
          // clip and align the end, then turn both bounds into frame numbers
          first_r <= fr_first;
          last_r  <= fr_last;
          state_r <= S_PREP1;
        end
        S_PREP1: begin
          word_r  <= first_r[6 +: WORD_AW];
          state_r <= (skip_r || first_r >= last_r) ? S_FIN : S_RW_RD;
        end
        S_RW_RD:  state_r <= S_RW_MOD;
        S_RW_MOD: begin
          chg_r   <= rw_chg;
          state_r <= S_RW_CNT;
        end
        S_RW_CNT: begin
          if (op_r == OP_ADD) begin
            man_r  <= man_r + CNT_W'(popcount(chg_r));
            free_r <= free_r + CNT_W'(popcount(chg_r));
          end else begin
            free_r <= free_r - CNT_W'(popcount(chg_r));
          end
          if (word_r == w_last) begin
            state_r <= S_FIN;
          end else begin
            word_r  <= word_r + WORD_AW'(1);
            state_r <= S_RW_RD;
          end
        end
        S_SC_RD: state_r <= S_SC_CHK;
        S_SC_CHK: begin
          if (avail != 64'h0) begin
            free_r  <= free_r - CNT_W'(1);
            alloc_r <= alloc_r + CNT_W'(1);
            paddr_r <= f_addr[PADDR_W-1:0];
            state_r <= S_FIN;
          end else if (word_r == WORD_AW'(MAP_WORDS - 1)) begin
            status_r <= ST_EXHAUSTED;
            state_r  <= S_FIN;
          end else begin
            word_r  <= word_r + WORD_AW'(1);
            state_r <= S_SC_RD;
          end
        end
        S_PT_RD: state_r <= S_PT_CHK;
        S_PT_CHK: begin
          if (op_r == OP_QUERY) begin
            qm_r <= rd_q.managed[bit_r];
            qa_r <= rd_q.managed[bit_r] && rd_q.taken[bit_r];
          end else if (!rd_q.managed[bit_r]) begin
            status_r <= ST_UNMANAGED;
          end else if (!rd_q.owned[bit_r]) begin
            status_r <= rd_q.taken[bit_r] ? ST_RESERVED : ST_DUP_FREE;
          end else if (!rd_q.taken[bit_r]) begin
            status_r <= ST_DUP_FREE;
          end else begin
            free_r  <= free_r + CNT_W'(1);
            alloc_r <= alloc_r - CNT_W'(1);
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_r.status          <= status_r;
            out_r.page_address    <= paddr_r;
            out_r.is_managed      <= qm_r;
            out_r.is_allocated    <= qa_r;
            out_r.managed_count   <= man_r;
            out_r.free_count      <= free_r;
            out_r.allocated_count <= alloc_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // once sealed, every managed frame is either free or allocated
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    sealed_r |-> (man_r == free_r + alloc_r))
    else $error("page counters out of balance");

  a_free_le_man: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= man_r)
    else $error("more free pages than managed");

  a_no_range_sealed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RW_CNT) |-> !sealed_r)
    else $error("range marking after seal");

  a_seal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(sealed_r) && $past(rst_n) |-> sealed_r)
    else $error("sealed flag dropped");

endmodule

[verif/bitmap_page_frame_allocator_checker.sv]
// Checker for the bitmap page-frame allocator: watches both channels, predicts each result beat.
// Depends on bpfa_pkg for sizes, operation and status codes and the beat types.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_checker
  import bpfa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending
);

  bit              usable_map [FRAMES];
  bit              busy_map   [FRAMES];
  bit              lent_map   [FRAMES];
  logic [CNT_W-1:0] usable_cnt, idle_cnt, lent_cnt;
  bit              locked;
  out_beat_t       awaited_q [$];

  function automatic out_beat_t allocator_next(in_beat_t b);
    out_beat_t   r;
    logic [63:0] lo, hi;
    int unsigned f, last;
    r = '0;
    case (op_t'(b.operation))
      OP_ADD: begin
        if (locked) r.status = ST_SEALED;
        else if (b.extent != 0 && b.address < ADDR_LIMIT) begin
          hi = b.address + b.extent;
          if (hi < b.address || hi > ADDR_LIMIT) hi = ADDR_LIMIT;
          lo = (b.address + OFFSET_MASK) & ~OFFSET_MASK;
          hi = hi & ~OFFSET_MASK;
          if (lo < hi) begin
            last = 32'(hi >> PAGE_BITS);
            for (f = 32'(lo >> PAGE_BITS); f < last; f++)
              if (!usable_map[f]) begin
                usable_map[f] = 1;
                busy_map[f] = 0;
                usable_cnt++;
                idle_cnt++;
              end
          end
        end
      end
      OP_RESERVE: begin
        if (locked) r.status = ST_SEALED;
        else begin
          lo = b.address & ~OFFSET_MASK;
          hi = (b.extent + OFFSET_MASK) & ~OFFSET_MASK;
          if (lo < ADDR_LIMIT) begin
            if (hi > ADDR_LIMIT || hi < lo) hi = ADDR_LIMIT;
            last = 32'(hi >> PAGE_BITS);
            for (f = 32'(lo >> PAGE_BITS); f < last; f++)
              if (usable_map[f] && !busy_map[f]) begin
                busy_map[f] = 1;
                idle_cnt--;
              end
          end
        end
      end
      OP_SEAL: begin
        if (locked) r.status = ST_SEALED;
        else if (idle_cnt == 0) r.status = ST_NONE_FREE;
        else begin
          lent_cnt = usable_cnt - idle_cnt;
          locked = 1;
        end
      end
      OP_ALLOC: begin
        if (!locked) r.status = ST_NOT_SEALED;
        else begin
          r.status = ST_EXHAUSTED;
          for (f = 0; f < FRAMES; f++)
            if (usable_map[f] && !busy_map[f]) begin
              busy_map[f] = 1;
              lent_map[f] = 1;
              idle_cnt--;
              lent_cnt++;
              r.page_address = PADDR_W'(64'(f) << PAGE_BITS);
              r.status = ST_OK;
              break;
            end
        end
      end
      OP_FREE: begin
        if (!locked) r.status = ST_NOT_SEALED;
        else if ((b.address & OFFSET_MASK) != 0 || b.address >= ADDR_LIMIT)
          r.status = ST_BAD_ADDR;
        else begin
          f = 32'(b.address >> PAGE_BITS);
          if (!usable_map[f]) r.status = ST_UNMANAGED;
          else if (!lent_map[f]) r.status = busy_map[f] ? ST_RESERVED : ST_DUP_FREE;
          else if (!busy_map[f]) r.status = ST_DUP_FREE;
          else begin
            lent_map[f] = 0;
            busy_map[f] = 0;
            idle_cnt++;
            lent_cnt--;
          end
        end
      end
      OP_QUERY: begin
        if ((b.address & OFFSET_MASK) == 0 && b.address < ADDR_LIMIT) begin
          f = 32'(b.address >> PAGE_BITS);
          if (usable_map[f]) begin
            r.is_managed = 1;
            r.is_allocated = busy_map[f];
          end
        end
      end
      default: ;
    endcase
    r.managed_count = usable_cnt;
    r.free_count = idle_cnt;
    r.allocated_count = lent_cnt;
    return r;
  endfunction

  assign pending = awaited_q.size();

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      foreach (usable_map[i]) begin
        usable_map[i] = 0;
        busy_map[i] = 1;
        lent_map[i] = 0;
      end
      usable_cnt = 0;
      idle_cnt = 0;
      lent_cnt = 0;
      locked = 0;
      awaited_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %p", out_data);
        end else begin
          want = awaited_q.pop_front();
          if (out_data.status !== want.status || out_data.page_address !== want.page_address ||
              out_data.is_managed !== want.is_managed ||
              out_data.is_allocated !== want.is_allocated ||
              out_data.managed_count !== want.managed_count ||
              out_data.free_count !== want.free_count ||
              out_data.allocated_count !== want.allocated_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch at %0t: expected %p, got %p", $realtime, want, out_data);
          end
        end
      end
      if (in_valid && !in_stall) awaited_q.push_back(allocator_next(in_data));
    end
  end

endmodule

[verif/bitmap_page_frame_allocator_tb.sv]
// Testbench top for the bitmap page-frame allocator: clock, reset, stimulus and verdict.
// Depends on bpfa_pkg, the block itself and bitmap_page_frame_allocator_checker.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;

  localparam int IDLE_LIMIT = 60000;
  localparam logic [63:0] PG = 64'h1000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  bit        calm;
  int        quiet_cycles;

  bitmap_page_frame_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  bitmap_page_frame_allocator_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Mostly no pause, often a short one, now and then a long one; none at all while calm.
  function automatic int pause_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure: stall for random stretches, same mix as the sender.
  initial begin
    int n;
    out_stall = 0;
    forever begin
      @(posedge clk);
      n = pause_len();
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one beat after a random gap and hold it until the block takes it.
  task automatic send_beat(op_t op, logic [63:0] a, logic [63:0] e);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{operation: op, address: a, extent: e};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Pick a free target: mostly pages in the managed low region, plus the odd
  // unaligned, out-of-range, top-of-memory or unmanaged address.
  function automatic logic [63:0] pick_page();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 64'($urandom_range(0, 1100)) * PG;
    if (p < 85) return 64'($urandom_range(0, 1100)) * PG + 64'($urandom_range(1, 4095));
    if (p < 90) return ADDR_LIMIT - PG * 64'($urandom_range(1, 3));
    if (p < 95) return {$urandom, $urandom};
    return 64'($urandom_range(2000, FRAMES - 8)) * PG;
  endfunction

  initial begin
    int k;
    int bias;
    logic [63:0] a;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    calm = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Directed: the unsealed corners first.
    send_beat(OP_SEAL, 0, 0);                       // nothing free yet
    send_beat(OP_ALLOC, 0, 0);                      // before seal
    send_beat(OP_FREE, 0, 0);
    send_beat(OP_QUERY, 0, 0);
    send_beat(OP_ADD, '1, '1);                      // base beyond limit
    send_beat(OP_ADD, 64'h4000, 0);                 // zero length
    send_beat(OP_ADD, ADDR_LIMIT - 3 * PG + 5, '1); // wraps, clipped to the limit
    send_beat(OP_ADD, 64'h123, 64'h1800);           // aligns to nothing
    send_beat(OP_ADD, 0, 64'h20_0000);              // first 512 frames
    send_beat(OP_RESERVE, 0, 0);
    send_beat(OP_RESERVE, ADDR_LIMIT - PG, '1);     // end wraps on alignment
    send_beat(OP_RESERVE, 64'h1_0fff, 64'h1_3001);
    send_beat(OP_RESERVE, '1, 0);
    send_beat(OP_RSVD6, '1, '1);
    send_beat(OP_RSVD7, 0, 0);
    send_beat(OP_QUERY, ADDR_LIMIT - PG, 0);
    send_beat(OP_QUERY, 64'h1_1001, 0);

    // Random usable and reserved ranges within the low region, plus noise.
    for (k = 0; k < 30; k++) begin
      a = 64'($urandom_range(0, 1000)) * PG + 64'($urandom_range(0, 1) * $urandom_range(0, 4095));
      case ($urandom_range(0, 3))
        0, 1: send_beat(OP_ADD, a, 64'($urandom_range(1, 64)) * PG + 64'($urandom_range(0, 4095)));
        2:    send_beat(OP_RESERVE, a, a + 64'($urandom_range(0, 8)) * PG);
        3:    send_beat(op_t'($urandom_range(0, 1)), {1'b1, 31'($urandom), $urandom},
                        {$urandom, $urandom});
      endcase
    end

    send_beat(OP_SEAL, 0, 0);
    send_beat(OP_SEAL, 0, 0);                       // second seal refused
    send_beat(OP_ADD, 0, 64'h1000);                 // ranges refused once sealed
    send_beat(OP_RESERVE, 0, '1);

    // Random sealed traffic, in blocks that lean towards allocate or free so
    // that the pool both runs dry and refills.
    for (k = 0; k < 1700; k++) begin
      if (k % 150 == 0) begin
        bias = $urandom_range(15, 75);
        calm = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 99) < 90)
        1'b1: begin
          if ($urandom_range(0, 99) < bias) send_beat(OP_ALLOC, {$urandom, $urandom}, 0);
          else if ($urandom_range(0, 3) != 0) send_beat(OP_FREE, pick_page(), {$urandom, $urandom});
          else send_beat(OP_QUERY, pick_page(), 0);
        end
        default: send_beat(op_t'($urandom_range(0, 7)), {$urandom, $urandom}, {$urandom, $urandom});
      endcase
    end
    in_valid <= 0;
    calm = 0;

    // let the checker record the last beat before polling its backlog
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
